### sv/bcm_pkg.sv
`default_nettype none

package bcm_pkg;

	localparam logic [1:0] FUNC_ACC   = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] CFG_COND_MIN  = 2'd0;
	localparam logic [1:0] CFG_BIN_WIDTH = 2'd1;
	localparam logic [1:0] CFG_BIN_RECIP = 2'd2;
	localparam logic [1:0] CFG_BINS_USED = 2'd3;

	localparam logic ALU_MUL = 1'b0;
	localparam logic ALU_DIV = 1'b1;

	localparam logic [5:0] MUL_STEPS = 6'd32;
	localparam logic [5:0] DIV_STEPS = 6'd56;

	localparam logic [23:0] CNT_MAX = 24'hFF_FFFF;
	localparam logic [55:0] SUM_MAX = {1'b0, {55{1'b1}}};
	localparam logic [55:0] SUM_MIN = {1'b1, {55{1'b0}}};

	typedef struct packed {
		logic [55:0] sum;
		logic [23:0] cnt;
	} bin_t;

	typedef struct packed {
		logic start;
		logic op;
	} alu_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_stat_t;

endpackage

`default_nettype wire

### sv/bcm_alu.sv
`default_nettype none

module bcm_alu (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bcm_pkg::alu_cmd_t cmd,
	input  wire logic [31:0]      opa,
	input  wire logic [55:0]      opb,
	output bcm_pkg::alu_stat_t    stat,
	output logic      [31:0]      hi,
	output logic      [55:0]      lo
);
	import bcm_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic        op_q;
	logic [5:0]  cnt_q;
	logic [31:0] b_q;
	logic [31:0] hi_q;
	logic [55:0] lo_q;

	logic [32:0] add_a;
	logic [32:0] add_b;
	logic        add_c;
	logic [32:0] add_s;
	logic [31:0] hi_n;
	logic [55:0] lo_n;

	always_comb begin
		if (op_q == ALU_MUL) begin
			add_a = {1'b0, hi_q};
			add_b = lo_q[0] ? {1'b0, b_q} : 33'd0;
			add_c = 1'b0;
		end else begin
			add_a = {8'b0, hi_q[23:0], lo_q[55]};
			add_b = ~{9'b0, b_q[23:0]};
			add_c = 1'b1;
		end
		add_s = add_a + add_b + {32'b0, add_c};
		if (op_q == ALU_MUL) begin
			hi_n = add_s[32:1];
			lo_n = {lo_q[55:32], add_s[0], lo_q[31:1]};
		end else if (add_s[32]) begin
			hi_n = add_a[31:0];
			lo_n = {lo_q[54:0], 1'b0};
		end else begin
			hi_n = add_s[31:0];
			lo_n = {lo_q[54:0], 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ALU_MUL;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q   <= cmd.op;
				cnt_q  <= (cmd.op == ALU_MUL) ? MUL_STEPS - 6'd1 : DIV_STEPS - 6'd1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hi_q <= 32'd0;
			lo_q <= opb;
			b_q  <= opa;
		end else if (busy_q) begin
			hi_q <= hi_n;
			lo_q <= lo_n;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign hi        = hi_q;
	assign lo        = lo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("start while busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("done without a finished run");

	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !cmd.start && cnt_q == 6'd0) |=> done_q)
		else $error("last step without done");

endmodule

`default_nettype wire

### sv/bcm_bins.sv
`default_nettype none

module bcm_bins #(
	parameter int NBINS = 64
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [$clog2(NBINS)-1:0]     waddr,
	input  wire bcm_pkg::bin_t                wdata,
	input  wire logic [$clog2(NBINS)-1:0]     raddr,
	output bcm_pkg::bin_t                     rdata
);
	import bcm_pkg::*;

	bin_t mem [NBINS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### sv/binned_conditional_mean_top.sv
// Binned conditional average histogram.
// Input channel (in_valid/in_ready) takes one item per beat: func selects
// accumulate, read one bin or clear all bins. Output channel
// (out_valid/out_ready) returns exactly one result beat for every input beat.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// write takes effect at that clock edge. The user must write them only while
// the block is idle; the block itself does not enforce it. One item is in
// work at a time; all multiplies and divides run through one shared
// shift-add/subtract unit, one bit per cycle. An accumulate that hits a bin
// goes through index multiply, bin access, center multiply and mean division;
// a read of a bin in use through bin access, center multiply and, if its
// count is nonzero, mean division. An accumulate past the last bin ends after
// the index multiply, one below cond_min skips it if bin_recip is nonzero;
// a read of a bin not in use and an unused func go straight to the result;
// clear writes all NBINS entries, one entry per cycle. in_ready returns in
// the cycle out_valid is set. After reset a clear sweep runs, in_ready low.
// The finished result sits in an output register; a new item is accepted
// while it waits, and the block holds its next result until out_ready.
`default_nettype none

module binned_conditional_mean_top #(
	parameter int NBINS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         func,
	input  wire logic signed [31:0] cond_value,
	input  wire logic signed [31:0] var_value,
	input  wire logic [5:0]         read_bin,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    in_range,
	output logic [5:0]              bin_index,
	output logic signed [31:0]      bin_center,
	output logic signed [55:0]      bin_sum,
	output logic [23:0]             bin_count,
	output logic signed [31:0]      bin_mean
);
	import bcm_pkg::*;

	localparam int IW = $clog2(NBINS);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_IDX  = 4'd2;
	localparam logic [3:0] S_IDXW = 4'd3;
	localparam logic [3:0] S_RD   = 4'd4;
	localparam logic [3:0] S_UPD  = 4'd5;
	localparam logic [3:0] S_CTR  = 4'd6;
	localparam logic [3:0] S_CTRW = 4'd7;
	localparam logic [3:0] S_MEAN = 4'd8;
	localparam logic [3:0] S_DIVW = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	function automatic logic [31:0] sat32(input logic [63:0] v);
		logic ok;
		ok = (&v[63:31]) || (~|v[63:31]);
		if (ok) begin
			return v[31:0];
		end else if (v[63]) begin
			return 32'h8000_0000;
		end else begin
			return 32'h7FFF_FFFF;
		end
	endfunction

	logic [31:0] cond_min_q;
	logic [30:0] bin_width_q;
	logic [31:0] bin_recip_q;
	logic [6:0]  bins_used_q;

	logic [3:0]    state_q;
	logic          clr_item_q;
	logic [IW-1:0] clr_addr_q;
	logic          out_valid_q;

	logic [1:0]    func_q;
	logic [32:0]   diff_q;
	logic [31:0]   var_q;
	logic [IW-1:0] idx_q;

	logic        res_in_range_q;
	logic [5:0]  res_idx_q;
	logic [31:0] res_center_q;
	logic [55:0] res_sum_q;
	logic [23:0] res_cnt_q;
	logic [31:0] res_mean_q;

	logic        out_in_range_q;
	logic [5:0]  out_idx_q;
	logic [31:0] out_center_q;
	logic [55:0] out_sum_q;
	logic [23:0] out_cnt_q;
	logic [31:0] out_mean_q;

	logic [31:0] limit;
	logic        in_fire;
	logic        fin_go;
	logic        idx_out;

	alu_cmd_t    alu_cmd;
	alu_stat_t   alu_stat;
	logic [31:0] alu_opa;
	logic [55:0] alu_opb;
	logic [31:0] alu_hi;
	logic [55:0] alu_lo;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	bin_t          mem_wdata;
	bin_t          mem_rdata;

	logic [56:0] upd_sum;
	logic [55:0] new_sum;
	logic [23:0] new_cnt;
	logic [55:0] sum_abs;
	logic [56:0] quo_signed;
	logic [63:0] center_full;

	assign limit   = (32'(bins_used_q) < 32'(NBINS)) ? 32'(bins_used_q) : 32'(NBINS);
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign fin_go   = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign idx_out  = diff_q[32] && (bin_recip_q != 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cond_min_q  <= 32'd0;
			bin_width_q <= 31'd65536;
			bin_recip_q <= 32'd65536;
			bins_used_q <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COND_MIN:  cond_min_q  <= cfg_data;
				CFG_BIN_WIDTH: bin_width_q <= cfg_data[30:0];
				CFG_BIN_RECIP: bin_recip_q <= cfg_data;
				CFG_BINS_USED: bins_used_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		alu_cmd = '0;
		alu_opa = 32'd0;
		alu_opb = 56'd0;
		case (state_q)
			S_IDX: begin
				alu_cmd.start = !idx_out;
				alu_cmd.op    = ALU_MUL;
				alu_opa       = bin_recip_q;
				alu_opb       = diff_q[32] ? 56'd0 : {24'd0, diff_q[31:0]};
			end
			S_CTR: begin
				alu_cmd.start = 1'b1;
				alu_cmd.op    = ALU_MUL;
				alu_opa       = {1'b0, bin_width_q};
				alu_opb       = 56'({idx_q, 1'b1});
			end
			S_MEAN: begin
				alu_cmd.start = (res_cnt_q != 24'd0);
				alu_cmd.op    = ALU_DIV;
				alu_opa       = {8'd0, res_cnt_q};
				alu_opb       = sum_abs;
			end
			default: ;
		endcase
	end

	bcm_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (alu_cmd),
		.opa    (alu_opa),
		.opb    (alu_opb),
		.stat   (alu_stat),
		.hi     (alu_hi),
		.lo     (alu_lo)
	);

	always_comb begin
		upd_sum = {mem_rdata.sum[55], mem_rdata.sum} + {{25{var_q[31]}}, var_q};
		if (upd_sum[56] != upd_sum[55]) begin
			new_sum = upd_sum[56] ? SUM_MIN : SUM_MAX;
		end else begin
			new_sum = upd_sum[55:0];
		end
		new_cnt     = (mem_rdata.cnt == CNT_MAX) ? mem_rdata.cnt : mem_rdata.cnt + 24'd1;
		sum_abs     = res_sum_q[55] ? 56'd0 - res_sum_q : res_sum_q;
		quo_signed  = res_sum_q[55] ? 57'd0 - {1'b0, alu_lo} : {1'b0, alu_lo};
		center_full = {{32{cond_min_q[31]}}, cond_min_q} + {1'b0, alu_hi, alu_lo[31:1]};
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '0;
		if (state_q == S_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
		end else if (state_q == S_UPD && func_q == FUNC_ACC) begin
			mem_we        = 1'b1;
			mem_wdata.sum = new_sum;
			mem_wdata.cnt = new_cnt;
		end
	end

	bcm_bins #(
		.NBINS (NBINS)
	) u_bins (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (idx_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_item_q  <= 1'b0;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_addr_q <= clr_addr_q + IW'(1);
					if (clr_addr_q == IW'(NBINS - 1)) begin
						clr_item_q <= 1'b0;
						state_q    <= clr_item_q ? S_FIN : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						case (func)
							FUNC_ACC: state_q <= S_IDX;
							FUNC_READ: begin
								if (32'(read_bin) < limit) begin
									state_q <= S_RD;
								end else begin
									state_q <= S_FIN;
								end
							end
							FUNC_CLEAR: begin
								clr_item_q <= 1'b1;
								clr_addr_q <= '0;
								state_q    <= S_CLR;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_IDX:  state_q <= idx_out ? S_FIN : S_IDXW;
				S_IDXW: begin
					if (alu_stat.done) begin
						state_q <= (alu_hi < limit) ? S_RD : S_FIN;
					end
				end
				S_RD:   state_q <= S_UPD;
				S_UPD:  state_q <= S_CTR;
				S_CTR:  state_q <= S_CTRW;
				S_CTRW: begin
					if (alu_stat.done) begin
						state_q <= S_MEAN;
					end
				end
				S_MEAN: state_q <= (res_cnt_q != 24'd0) ? S_DIVW : S_FIN;
				S_DIVW: begin
					if (alu_stat.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					func_q         <= func;
					diff_q         <= {cond_value[31], cond_value} - {cond_min_q[31], cond_min_q};
					var_q          <= var_value;
					idx_q          <= IW'(read_bin);
					res_in_range_q <= (func == FUNC_READ) && (32'(read_bin) < limit);
					res_idx_q      <= (func == FUNC_READ) ? read_bin : 6'd0;
					res_center_q   <= 32'd0;
					res_sum_q      <= 56'd0;
					res_cnt_q      <= 24'd0;
					res_mean_q     <= 32'd0;
				end
			end
			S_IDXW: begin
				if (alu_stat.done && alu_hi < limit) begin
					idx_q          <= IW'(alu_hi);
					res_in_range_q <= 1'b1;
					res_idx_q      <= 6'(alu_hi);
				end
			end
			S_UPD: begin
				if (func_q == FUNC_ACC) begin
					res_sum_q <= new_sum;
					res_cnt_q <= new_cnt;
				end else begin
					res_sum_q <= mem_rdata.sum;
					res_cnt_q <= mem_rdata.cnt;
				end
			end
			S_CTRW: begin
				if (alu_stat.done) begin
					res_center_q <= sat32(center_full);
				end
			end
			S_MEAN: begin
				if (res_cnt_q == 24'd0) begin
					res_mean_q <= sat32({{8{res_sum_q[55]}}, res_sum_q});
				end
			end
			S_DIVW: begin
				if (alu_stat.done) begin
					res_mean_q <= sat32({{7{quo_signed[56]}}, quo_signed});
				end
			end
			default: ;
		endcase
		if (fin_go) begin
			out_in_range_q <= res_in_range_q;
			out_idx_q      <= res_idx_q;
			out_center_q   <= res_center_q;
			out_sum_q      <= res_sum_q;
			out_cnt_q      <= res_cnt_q;
			out_mean_q     <= res_mean_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign in_range   = out_in_range_q;
	assign bin_index  = out_idx_q;
	assign bin_center = out_center_q;
	assign bin_sum    = out_sum_q;
	assign bin_count  = out_cnt_q;
	assign bin_mean   = out_mean_q;

	a_upd_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && func_q == FUNC_ACC) |-> (32'(idx_q) < limit))
		else $error("bin update outside the bins in use");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid_q && state_q == S_IDLE)
		else $error("result not presented");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != S_IDLE)
		else $error("accepted beat dropped");

	a_alu_busy_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_stat.busy |-> (state_q == S_IDXW || state_q == S_CTRW || state_q == S_DIVW))
		else $error("shared unit busy outside a wait state");

endmodule

`default_nettype wire

### tb/tb_binned_conditional_mean_top.sv
`timescale 1ns / 1ps

module tb_binned_conditional_mean_top;
	import bcm_pkg::*;

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam longint SUM_HI = 64'sd36028797018963967;
	localparam longint SUM_LO = -SUM_HI - 1;
	localparam int NB = 64;
	localparam int PHASE_ITEMS = 120;

	typedef struct packed {
		logic               in_range;
		logic [5:0]         idx;
		logic signed [31:0] center;
		logic signed [55:0] sum;
		logic [23:0]        cnt;
		logic signed [31:0] mean;
	} bcm_res_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  f;
		logic [31:0] cond;
		logic [31:0] vv;
		logic [5:0]  rb;
		logic        chk;
		bcm_res_t    res;
		logic [1:0]  ridx;
		logic [31:0] rdata;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         func;
	logic signed [31:0] cond_value;
	logic signed [31:0] var_value;
	logic [5:0]         read_bin;
	logic               out_valid;
	logic               out_ready;
	logic               in_range;
	logic [5:0]         bin_index;
	logic signed [31:0] bin_center;
	logic signed [55:0] bin_sum;
	logic [23:0]        bin_count;
	logic signed [31:0] bin_mean;

	binned_conditional_mean_top #(.NBINS(NB)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.cond_value(cond_value),
		.var_value (var_value),
		.read_bin  (read_bin),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.in_range  (in_range),
		.bin_index (bin_index),
		.bin_center(bin_center),
		.bin_sum   (bin_sum),
		.bin_count (bin_count),
		.bin_mean  (bin_mean)
	);

	// histogram copy: configuration and per-bin state
	logic signed [31:0] h_cond_min  = 32'sd0;
	logic [30:0]        h_bin_width = 31'd65536;
	logic [31:0]        h_bin_recip = 32'd65536;
	logic [6:0]         h_bins_used = 7'd64;
	logic signed [55:0] h_sum [NB];
	logic [23:0]        h_hits [NB];

	bcm_res_t    pending[$];
	stim_row_t   stim_tab[$];
	bcm_res_t    got, want, pred, cur_exp;
	logic        cur_chk;
	int          errors, n_items, n_checked, n_inbin;
	int unsigned snd_idle, rcv_idle;

	logic [31:0] ph_cm [6] = '{32'h0000_0000, 32'h8000_0000, 32'hFC18_0000,
		32'h7FFF_FFFF, 32'h1234_5678, 32'hFFFB_0000};
	logic [31:0] ph_w [6] = '{32'd65536, 32'h7FFF_FFFF, 32'd196608, 32'd1, 32'd4096,
		32'h0010_0000};
	logic [31:0] ph_r [6] = '{32'd65536, 32'd2, 32'd21845, 32'hFFFF_FFFF, 32'h0010_0000,
		32'd0};
	logic [31:0] ph_n [6] = '{32'd64, 32'd1, 32'd20, 32'd127, 32'd0, 32'd33};

	function automatic logic signed [31:0] sat32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic int unsigned bin_limit();
		return (h_bins_used < NB) ? h_bins_used : NB;
	endfunction

	function automatic bcm_res_t bin_report(input int unsigned b);
		bcm_res_t    r;
		logic [63:0] half;
		longint      sm, cn;
		half = ({33'd0, h_bin_width} * (64'(b) * 2 + 1)) >> 1;
		sm = longint'(h_sum[b]);
		cn = h_hits[b];
		r.in_range = 1'b1;
		r.idx = b[5:0];
		r.center = sat32(longint'(h_cond_min) + longint'(half));
		r.sum = h_sum[b];
		r.cnt = h_hits[b];
		r.mean = sat32((cn != 0) ? sm / cn : sm);
		return r;
	endfunction

	function automatic bcm_res_t histo_step(input logic [1:0] f, input logic signed [31:0] c,
			input logic signed [31:0] v, input logic [5:0] rb);
		bcm_res_t    r;
		longint      diff, s;
		logic [63:0] mag, prod;
		int unsigned b;
		r = '0;
		case (f)
			FUNC_ACC: begin
				diff = longint'(c) - longint'(h_cond_min);
				mag = (diff < 0) ? 64'(-diff) : 64'(diff);
				prod = mag * {32'd0, h_bin_recip};
				if (!(diff < 0 && prod != 0) && prod[63:32] < bin_limit()) begin
					b = prod[37:32];
					s = longint'(h_sum[b]) + longint'(v);
					if (s > SUM_HI) s = SUM_HI;
					if (s < SUM_LO) s = SUM_LO;
					h_sum[b] = s[55:0];
					if (h_hits[b] != CNT_MAX) h_hits[b] = h_hits[b] + 1'b1;
					r = bin_report(b);
				end
			end
			FUNC_READ: begin
				if (rb < bin_limit()) r = bin_report(rb);
				else r.idx = rb;
			end
			FUNC_CLEAR: begin
				for (int i = 0; i < NB; i++) begin
					h_sum[i] = '0;
					h_hits[i] = '0;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic bcm_res_t mk_res(input logic ir, input logic [5:0] b,
			input logic [31:0] ctr, input logic [55:0] sm, input logic [23:0] cn,
			input logic [31:0] mn);
		return {ir, b, ctr, sm, cn, mn};
	endfunction

	function automatic void row_item(input logic [1:0] f, input logic [31:0] c,
			input logic [31:0] v, input logic [5:0] rb);
		stim_row_t t;
		t = '{ROW_ITEM, f, c, v, rb, 1'b0, '0, 2'd0, 32'd0};
		stim_tab.push_back(t);
	endfunction

	function automatic void row_exp(input logic [1:0] f, input logic [31:0] c,
			input logic [31:0] v, input logic [5:0] rb, input bcm_res_t res);
		stim_row_t t;
		t = '{ROW_ITEM, f, c, v, rb, 1'b1, res, 2'd0, 32'd0};
		stim_tab.push_back(t);
	endfunction

	function automatic void row_reg(input logic [1:0] ri, input logic [31:0] d);
		stim_row_t t;
		t = '{ROW_REG, 2'd0, 32'd0, 32'd0, 6'd0, 1'b0, '0, ri, d};
		stim_tab.push_back(t);
	endfunction

	function automatic logic [31:0] pick_cond();
		longint k, c;
		if ($urandom_range(9) == 0) return $urandom;
		k = longint'($urandom_range(bin_limit() + 3)) - 2;
		c = longint'(h_cond_min) + k * longint'(h_bin_width)
			+ longint'($urandom_range(h_bin_width - 1));
		if (c > 64'sd2147483647) c = 64'sd2147483647;
		if (c < -64'sd2147483648) c = -64'sd2147483648;
		return c[31:0];
	endfunction

	task automatic send(input logic [1:0] f, input logic [31:0] c, input logic [31:0] v,
			input logic [5:0] rb, input logic chk, input bcm_res_t res);
		@(negedge clk);
		if ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < snd_idle);
		end
		in_valid <= 1'b1;
		func <= f;
		cond_value <= c;
		var_value <= v;
		read_bin <= rb;
		cur_chk = chk;
		cur_exp = res;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input logic [1:0] ri, input logic [31:0] d);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ri;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("tb: failure");
		$finish;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		if (cfg_we) begin
			case (cfg_index)
				CFG_COND_MIN:  h_cond_min = cfg_data;
				CFG_BIN_WIDTH: h_bin_width = cfg_data[30:0];
				CFG_BIN_RECIP: h_bin_recip = cfg_data;
				CFG_BINS_USED: h_bins_used = cfg_data[6:0];
				default: ;
			endcase
		end
		if (out_valid && out_ready) begin
			got = {in_range, bin_index, bin_center, bin_sum, bin_count, bin_mean};
			n_checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("tb: unexpected beat: idx %0d sum %0d", bin_index, bin_sum);
			end else begin
				want = pending.pop_front();
				if (got.in_range !== want.in_range || got.idx !== want.idx
						|| got.center !== want.center || got.sum !== want.sum
						|| got.cnt !== want.cnt || got.mean !== want.mean) begin
					errors++;
					if (errors <= 10)
						$display({"tb: mismatch (exp/got) in_range %0d/%0d idx %0d/%0d ",
							"center %0d/%0d sum %0d/%0d count %0d/%0d mean %0d/%0d"},
							want.in_range, got.in_range, want.idx, got.idx,
							want.center, got.center, want.sum, got.sum,
							want.cnt, got.cnt, want.mean, got.mean);
				end
				if (want.in_range) n_inbin++;
			end
		end
		if (in_valid && in_ready) begin
			pred = histo_step(func, cond_value, var_value, read_bin);
			pending.push_back(cur_chk ? cur_exp : pred);
			n_items++;
		end
	end

	initial begin
		logic [1:0]  f;
		logic [5:0]  rb;
		logic [31:0] v;
		int          r, n;

		for (int i = 0; i < NB; i++) begin
			h_sum[i] = '0;
			h_hits[i] = '0;
		end
		errors = 0;
		n_items = 0;
		n_checked = 0;
		n_inbin = 0;
		cur_chk = 1'b0;
		cur_exp = '0;
		snd_idle = 24;
		rcv_idle = 71;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_COND_MIN;
		cfg_data = 32'd0;
		in_valid = 1'b0;
		func = FUNC_ACC;
		cond_value = 32'sd0;
		var_value = 32'sd0;
		read_bin = 6'd0;
		out_ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		row_exp(FUNC_READ, 32'd0, 32'd0, 6'd0, mk_res(1, 0, 32768, 0, 0, 0));
		row_exp(FUNC_READ, 32'd0, 32'd0, 6'd63, mk_res(1, 63, 4161536, 0, 0, 0));
		row_exp(FUNC_ACC, 32'd0, 32'd327680, 6'd0, mk_res(1, 0, 32768, 327680, 1, 327680));
		row_exp(FUNC_ACC, 32'h7FFF_FFFF, 32'h8000_0000, 6'd0, '0);
		row_exp(FUNC_ACC, 32'h8000_0000, 32'h7FFF_FFFF, 6'd0, '0);
		row_item(FUNC_ACC, 32'h003F_FFFF, 32'h7FFF_FFFF, 6'd0);
		row_exp(FUNC_ACC, 32'h0040_0000, 32'd5, 6'd0, '0);
		row_item(FUNC_ACC, 32'h003F_0000, 32'h8000_0000, 6'd0);
		row_exp(FUNC_ACC, 32'hFFFF_FFFF, 32'd1, 6'd0, '0);
		row_item(FUNC_READ, 32'd0, 32'd0, 6'd63);
		row_exp(FUNC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, '0);
		row_exp(FUNC_CLEAR, 32'd0, 32'd0, 6'd0, '0);
		row_exp(FUNC_READ, 32'd0, 32'd0, 6'd63, mk_res(1, 63, 4161536, 0, 0, 0));
		row_reg(CFG_BINS_USED, 32'd127);
		row_item(FUNC_ACC, 32'h003F_0000, 32'd7, 6'd0);
		row_reg(CFG_BINS_USED, 32'd0);
		row_exp(FUNC_READ, 32'd0, 32'd0, 6'd0, '0);
		row_exp(FUNC_ACC, 32'd0, 32'd9, 6'd0, '0);
		row_reg(CFG_BINS_USED, 32'd10);
		row_exp(FUNC_READ, 32'd0, 32'd0, 6'd10, mk_res(0, 10, 0, 0, 0, 0));
		row_item(FUNC_READ, 32'd0, 32'd0, 6'd9);
		row_reg(CFG_BIN_RECIP, 32'd0);
		row_reg(CFG_COND_MIN, 32'h0064_0000);
		row_item(FUNC_ACC, 32'h8000_0000, 32'd3, 6'd0);
		row_item(FUNC_ACC, 32'h7FFF_FFFF, 32'hFFFF_FFF7, 6'd0);
		row_item(FUNC_READ, 32'd0, 32'd0, 6'd0);
		row_reg(CFG_COND_MIN, 32'h7FFF_0000);
		row_reg(CFG_BIN_WIDTH, 32'h7FFF_FFFF);
		row_reg(CFG_BIN_RECIP, 32'd1);
		row_reg(CFG_BINS_USED, 32'd64);
		row_item(FUNC_READ, 32'd0, 32'd0, 6'd63);
		row_reg(CFG_COND_MIN, 32'h8000_0000);
		row_item(FUNC_READ, 32'd0, 32'd0, 6'd63);
		row_item(FUNC_ACC, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd0);
		row_item(FUNC_READ, 32'd0, 32'd0, 6'd0);

		foreach (stim_tab[i]) begin
			if (stim_tab[i].kind == ROW_REG)
				write_reg(stim_tab[i].ridx, stim_tab[i].rdata);
			else
				send(stim_tab[i].f, stim_tab[i].cond, stim_tab[i].vv, stim_tab[i].rb,
					stim_tab[i].chk, stim_tab[i].res);
		end

		for (int ph = 0; ph < 6; ph++) begin
			snd_idle = (ph < 2) ? 24 : (ph < 4) ? 71 : 0;
			rcv_idle = (ph < 2) ? 71 : (ph < 4) ? 24 : 0;
			write_reg(CFG_COND_MIN, ph_cm[ph]);
			write_reg(CFG_BIN_WIDTH, ph_w[ph]);
			write_reg(CFG_BIN_RECIP, ph_r[ph]);
			write_reg(CFG_BINS_USED, ph_n[ph]);
			n = 0;
			while (n < PHASE_ITEMS) begin
				r = $urandom_range(99);
				f = (r < 70) ? FUNC_ACC : (r < 92) ? FUNC_READ : (r < 94) ? FUNC_CLEAR
					: FUNC_NONE;
				v = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1048576) - 524288;
				rb = ($urandom_range(1) == 0 && bin_limit() > 0) ?
					6'($urandom_range(bin_limit() - 1)) : 6'($urandom_range(63));
				send(f, pick_cond(), v, rb, 1'b0, '0);
				n++;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);

		$display("tb: %0d items accepted over 6 register settings, %0d results checked",
			n_items, n_checked);
		$display("tb: %0d results hit a bin, %0d mismatches", n_inbin, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
